// ===== rtl/framed_serial_four_channel_pwm_top_defines.svh =====
// Assertion macros for the framed serial PWM block.
// They sample on clk and are disabled while rst_n is low.
`ifndef FRAMED_SERIAL_FOUR_CHANNEL_PWM_TOP_DEFINES_SVH
`define FRAMED_SERIAL_FOUR_CHANNEL_PWM_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framed pwm: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framed pwm: next-cycle check failed");

`endif

// ===== rtl/fsp_pkg.sv =====
package fsp_pkg;

    localparam int CHANNELS_DEF = 4;
    localparam int ON_W         = 4;
    localparam int POS_OUT_W    = 3;

    localparam logic [7:0]  HEADER_RST  = 8'hAA;
    localparam logic [7:0]  TRAILER_RST = 8'h55;
    localparam logic [15:0] TIMEOUT_RST = 16'd400;
    localparam logic [7:0]  PHASE_MAX   = 8'hFF;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_PWM     = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REPLY_NONE   = 2'd0,
        REPLY_ACCEPT = 2'd1,
        REPLY_ERROR  = 2'd2
    } reply_t;

    typedef enum logic [1:0] {
        REG_HEADER  = 2'd0,
        REG_TRAILER = 2'd1,
        REG_TIMEOUT = 2'd2
    } reg_index_t;

    typedef struct packed {
        reply_t                 reply;
        logic [POS_OUT_W-1:0]   frame_position;
        logic                   watch_active;
    } frame_status_t;

    // Packed so that channel_on lands in the lowest bits.
    typedef struct packed {
        logic                   watch_active;
        logic [POS_OUT_W-1:0]   frame_position;
        reply_t                 reply;
        logic [ON_W-1:0]        channel_on;
    } result_t;

endpackage

// ===== rtl/fsp_frame.sv =====
module fsp_frame #(
    parameter int CHANNELS = fsp_pkg::CHANNELS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       byte_en,
    input  logic                       tick_en,
    input  logic [7:0]                 rx_byte,
    input  logic [7:0]                 header_byte,
    input  logic [7:0]                 trailer_byte,
    input  logic [15:0]                timeout_ticks,
    output logic [CHANNELS-1:0][7:0]   duty_levels,
    output fsp_pkg::frame_status_t     status
);

    localparam int POS_W = $clog2(CHANNELS + 2);
    localparam logic [POS_W-1:0] LAST_DUTY_POS = POS_W'(CHANNELS);
    localparam logic [POS_W-1:0] TRAILER_POS   = POS_W'(CHANNELS + 1);
    localparam logic [POS_W-1:0] FIRST_POS     = POS_W'(1);

    logic [POS_W-1:0]          position_reg;
    logic [POS_W-1:0]          position_next;
    logic [15:0]               watch_count_reg;
    logic [15:0]               watch_count_next;
    logic [15:0]               count_inc;
    logic                      watch_running_reg;
    logic                      watch_running_next;
    logic [CHANNELS-1:0][7:0]  payload_reg;
    logic [CHANNELS-1:0][7:0]  duty_reg;
    logic                      payload_we;
    logic                      duty_load;
    fsp_pkg::reply_t           reply;
    logic [POS_W+2:0]          position_ext;

    assign count_inc = watch_count_reg + 16'd1;

    always_comb
    begin
        position_next      = position_reg;
        watch_count_next   = watch_count_reg;
        watch_running_next = watch_running_reg;
        reply              = fsp_pkg::REPLY_NONE;
        payload_we         = 1'b0;
        duty_load          = 1'b0;
        if (byte_en)
        begin
            if (position_reg == '0 && rx_byte == header_byte)
            begin
                position_next = FIRST_POS;
            end
            else if (position_reg != '0 && position_reg <= LAST_DUTY_POS)
            begin
                payload_we    = 1'b1;
                position_next = position_reg + FIRST_POS;
            end
            else if (position_reg == TRAILER_POS && rx_byte == trailer_byte)
            begin
                duty_load     = 1'b1;
                position_next = '0;
                reply         = fsp_pkg::REPLY_ACCEPT;
            end
            else
            begin
                position_next = '0;
                reply         = fsp_pkg::REPLY_ERROR;
            end
            // Every byte restarts the timeout from zero.
            watch_count_next   = '0;
            watch_running_next = (position_next != '0);
        end
        else if (tick_en && watch_running_reg)
        begin
            if (count_inc == timeout_ticks)
            begin
                position_next      = '0;
                watch_count_next   = '0;
                watch_running_next = 1'b0;
                reply              = fsp_pkg::REPLY_ERROR;
            end
            else
            begin
                watch_count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg      <= '0;
            watch_count_reg   <= '0;
            watch_running_reg <= 1'b0;
            duty_reg          <= '0;
        end
        else
        begin
            position_reg      <= position_next;
            watch_count_reg   <= watch_count_next;
            watch_running_reg <= watch_running_next;
            if (duty_load)
            begin
                duty_reg <= payload_reg;
            end
        end
    end

    // Duty bytes are staged here until the trailer confirms the frame.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (payload_we && position_reg == POS_W'(i + 1))
            begin
                payload_reg[i] <= rx_byte;
            end
        end
    end

    assign position_ext = {3'b000, position_next};

    assign duty_levels           = duty_reg;
    assign status.reply          = reply;
    assign status.frame_position = position_ext[fsp_pkg::POS_OUT_W-1:0];
    assign status.watch_active   = watch_running_next;

endmodule

// ===== rtl/fsp_pwm.sv =====
module fsp_pwm #(
    parameter int CHANNELS = fsp_pkg::CHANNELS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       tick_en,
    input  logic [CHANNELS-1:0][7:0]   duty_levels,
    output logic [fsp_pkg::ON_W-1:0]   channel_on
);

    logic [7:0] phase_reg;
    logic [7:0] phase_next;
    logic [7:0] phase_inc;

    assign phase_inc  = phase_reg + 8'd1;
    assign phase_next = (phase_inc == fsp_pkg::PHASE_MAX) ? 8'd0 : phase_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (tick_en)
        begin
            phase_reg <= phase_next;
        end
    end

    // Compare against the stepped phase, before the wrap at full scale.
    generate
        for (genvar i = 0; i < fsp_pkg::ON_W; i++)
        begin : g_on
            if (i < CHANNELS)
            begin : g_used
                assign channel_on[i] = tick_en && (phase_inc < duty_levels[i]);
            end
            else
            begin : g_unused
                assign channel_on[i] = 1'b0;
            end
        end
    endgenerate

endmodule

// ===== rtl/fsp_out_buf.sv =====
module fsp_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  fsp_pkg::result_t   push_data,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output fsp_pkg::result_t   out_data
);

    logic               out_valid_reg;
    logic               skid_valid_reg;
    fsp_pkg::result_t   out_data_reg;
    fsp_pkg::result_t   skid_data_reg;
    logic               pop;

    assign pop       = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if ((pop || !out_valid_reg) && push)
        begin
            out_data_reg <= push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

endmodule

// ===== rtl/framed_serial_four_channel_pwm_top.sv =====
// Each result word is registered in the output buffer before it appears on m_axis.
// Throughput: one input word per cycle while s_axis_tready is high; a two-word output
// buffer keeps s_axis_tready high while one finished word waits for m_axis_tready.
// Reset (rst_n low, asynchronous): frame position, timeout, PWM phase and duty levels
// clear to zero and the configuration registers return to 0xAA, 0x55 and 400.
`include "framed_serial_four_channel_pwm_top_defines.svh"

module framed_serial_four_channel_pwm_top #(
    parameter int CHANNELS = fsp_pkg::CHANNELS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]   s_axis_tuser,   // [1:0] opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [3:0] channel_on, [5:4] reply, [8:6] frame_position, [9] watch_active
    output logic [15:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    logic [7:0]                 header_reg;
    logic [7:0]                 trailer_reg;
    logic [15:0]                timeout_reg;
    logic                       accept;
    fsp_pkg::opcode_t           opcode;
    logic                       byte_en;
    logic                       pwm_en;
    logic                       tick_en;
    logic [CHANNELS-1:0][7:0]   duty_levels;
    fsp_pkg::frame_status_t     status;
    logic [fsp_pkg::ON_W-1:0]   channel_on;
    fsp_pkg::result_t           result;
    fsp_pkg::result_t           out_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg  <= fsp_pkg::HEADER_RST;
            trailer_reg <= fsp_pkg::TRAILER_RST;
            timeout_reg <= fsp_pkg::TIMEOUT_RST;
        end
        else if (cfg_valid)
        begin
            case (fsp_pkg::reg_index_t'(cfg_index))
                fsp_pkg::REG_HEADER:  header_reg  <= cfg_data[7:0];
                fsp_pkg::REG_TRAILER: trailer_reg <= cfg_data[7:0];
                fsp_pkg::REG_TIMEOUT: timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign opcode  = fsp_pkg::opcode_t'(s_axis_tuser);
    assign byte_en = accept && (opcode == fsp_pkg::OP_BYTE);
    assign pwm_en  = accept && (opcode == fsp_pkg::OP_PWM);
    assign tick_en = accept && (opcode == fsp_pkg::OP_TIMEOUT);

    fsp_frame #(
        .CHANNELS (CHANNELS)
    ) u_frame (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_en       (byte_en),
        .tick_en       (tick_en),
        .rx_byte       (s_axis_tdata),
        .header_byte   (header_reg),
        .trailer_byte  (trailer_reg),
        .timeout_ticks (timeout_reg),
        .duty_levels   (duty_levels),
        .status        (status)
    );

    fsp_pwm #(
        .CHANNELS (CHANNELS)
    ) u_pwm (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_en     (pwm_en),
        .duty_levels (duty_levels),
        .channel_on  (channel_on)
    );

    assign result.channel_on     = channel_on;
    assign result.reply          = status.reply;
    assign result.frame_position = status.frame_position;
    assign result.watch_active   = status.watch_active;

    fsp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (result),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_word)
    );

    assign m_axis_tdata = {6'b000000, out_word};

    `FSP_ASSERT_SAME(a_full_buffer_has_output, !s_axis_tready, m_axis_tvalid)
    `FSP_ASSERT_NEXT(a_accept_gives_output, accept, m_axis_tvalid)
    `FSP_ASSERT_SAME(a_accept_closes_frame, m_axis_tvalid && out_word.reply == fsp_pkg::REPLY_ACCEPT, out_word.frame_position == '0 && !out_word.watch_active)

endmodule

// ===== tb/sv/dimmer_result_checker.sv =====
`timescale 1ns / 1ps

module dimmer_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  in_data,
    input  logic [1:0]  in_user,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [15:0] out_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending_words,
    output int          checked_words,
    output int          frames_loaded,
    output int          error_replies
);

    logic [7:0]         header_cfg;
    logic [7:0]         trailer_cfg;
    logic [15:0]        timeout_cfg;
    logic [7:0]         duty [fsp_pkg::CHANNELS_DEF];
    logic [7:0]         payload [fsp_pkg::CHANNELS_DEF];
    logic [2:0]         pos;
    logic [7:0]         phase;
    logic [15:0]        watch_cnt;
    logic               watch_on;
    fsp_pkg::result_t   expected_results [$];
    int                 errors;
    int                 checked;
    int                 loaded;
    int                 err_seen;

    // Advances the dimmer state by one word and returns the status word it produces.
    function automatic fsp_pkg::result_t dimmer_step(input fsp_pkg::opcode_t op,
                                                     input logic [7:0] rx);
        fsp_pkg::result_t r;
        r = '0;
        case (op)
            fsp_pkg::OP_BYTE:
            begin
                if (pos == 0 && rx == header_cfg)
                    pos = 3'd1;
                else if (pos >= 1 && pos <= fsp_pkg::CHANNELS_DEF)
                begin
                    payload[pos - 1] = rx;
                    pos = pos + 3'd1;
                end
                else if (pos == fsp_pkg::CHANNELS_DEF + 1 && rx == trailer_cfg)
                begin
                    for (int i = 0; i < fsp_pkg::CHANNELS_DEF; i++)
                        duty[i] = payload[i];
                    pos = '0;
                    r.reply = fsp_pkg::REPLY_ACCEPT;
                end
                else
                begin
                    pos = '0;
                    r.reply = fsp_pkg::REPLY_ERROR;
                end
                // Every byte restarts the inactivity watch.
                watch_cnt = '0;
                watch_on = (pos != 0);
            end
            fsp_pkg::OP_PWM:
            begin
                phase = phase + 8'd1;
                for (int i = 0; i < fsp_pkg::CHANNELS_DEF; i++)
                    if (phase < duty[i])
                        r.channel_on[i] = 1'b1;
                if (phase == fsp_pkg::PHASE_MAX)
                    phase = '0;
            end
            fsp_pkg::OP_TIMEOUT:
            begin
                if (watch_on)
                begin
                    watch_cnt = watch_cnt + 16'd1;
                    if (watch_cnt == timeout_cfg)
                    begin
                        pos = '0;
                        watch_cnt = '0;
                        watch_on = 1'b0;
                        r.reply = fsp_pkg::REPLY_ERROR;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.frame_position = pos;
        r.watch_active = watch_on;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fsp_pkg::result_t got;
        fsp_pkg::result_t want;
        if (!rst_n)
        begin
            header_cfg = fsp_pkg::HEADER_RST;
            trailer_cfg = fsp_pkg::TRAILER_RST;
            timeout_cfg = fsp_pkg::TIMEOUT_RST;
            for (int i = 0; i < fsp_pkg::CHANNELS_DEF; i++)
            begin
                duty[i] = '0;
                payload[i] = '0;
            end
            pos = '0;
            phase = '0;
            watch_cnt = '0;
            watch_on = 1'b0;
            expected_results.delete();
            errors = 0;
            checked = 0;
            loaded = 0;
            err_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fsp_pkg::REG_HEADER:  header_cfg = cfg_data[7:0];
                    fsp_pkg::REG_TRAILER: trailer_cfg = cfg_data[7:0];
                    fsp_pkg::REG_TIMEOUT: timeout_cfg = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && in_ready)
                expected_results.push_back(dimmer_step(fsp_pkg::opcode_t'(in_user),
                                                       in_data));
            if (out_valid && out_ready)
            begin
                got = fsp_pkg::result_t'(out_data[9:0]);
                if (expected_results.size() == 0)
                begin
                    $error("result word %h arrived with nothing expected", out_data);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    checked++;
                    if (want.reply == fsp_pkg::REPLY_ACCEPT)
                        loaded++;
                    if (want.reply == fsp_pkg::REPLY_ERROR)
                        err_seen++;
                    if (got.channel_on !== want.channel_on)
                    begin
                        $error("channel_on: expected %h, got %h", want.channel_on,
                               got.channel_on);
                        errors++;
                    end
                    if (got.reply !== want.reply)
                    begin
                        $error("reply: expected %0d, got %0d", want.reply, got.reply);
                        errors++;
                    end
                    if (got.frame_position !== want.frame_position)
                    begin
                        $error("frame_position: expected %0d, got %0d",
                               want.frame_position, got.frame_position);
                        errors++;
                    end
                    if (got.watch_active !== want.watch_active)
                    begin
                        $error("watch_active: expected %0d, got %0d", want.watch_active,
                               got.watch_active);
                        errors++;
                    end
                end
            end
        end
        fail_count <= errors;
        pending_words <= expected_results.size();
        checked_words <= checked;
        frames_loaded <= loaded;
        error_replies <= err_seen;
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_WORDS = 80;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // [7:0] rx_byte
    fsp_pkg::opcode_t       s_axis_tuser;   // [1:0] opcode
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [3:0] channel_on, [5:4] reply, [8:6] frame_position, [9] watch_active
    logic [15:0]            m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    fsp_pkg::reg_index_t    cfg_index;
    logic [15:0]            cfg_data;

    int          fail_count;
    int          pending_words;
    int          checked_words;
    int          frames_loaded;
    int          error_replies;
    int          words_sent = 0;
    int          cycle_count = 0;
    bit          idling = 1'b1;
    bit          hold_output = 1'b0;
    logic [7:0]  hdr_mirror = fsp_pkg::HEADER_RST;
    logic [7:0]  trl_mirror = fsp_pkg::TRAILER_RST;
    logic [15:0] timeout_mirror = fsp_pkg::TIMEOUT_RST;

    framed_serial_four_channel_pwm_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    dimmer_result_checker result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_data       (s_axis_tdata),
        .in_user       (s_axis_tuser),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_data      (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_words (pending_words),
        .checked_words (checked_words),
        .frames_loaded (frames_loaded),
        .error_replies (error_replies)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic send_word(input fsp_pkg::opcode_t op, input logic [7:0] rx);
        int gap;
        gap = idling ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= rx;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        words_sent++;
    endtask

    // Stops sending and waits until every result word has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0) @(posedge clk);
    endtask

    task automatic write_reg(input fsp_pkg::reg_index_t idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            fsp_pkg::REG_HEADER:  hdr_mirror = val[7:0];
            fsp_pkg::REG_TRAILER: trl_mirror = val[7:0];
            default:              timeout_mirror = val;
        endcase
        @(posedge clk);
    endtask

    task automatic sprinkle_ticks(input bit run_out);
        int n;
        n = $urandom_range(0, 2);
        repeat (n) send_word(fsp_pkg::OP_PWM, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 1 && timeout_mirror > 1)
            send_word(fsp_pkg::OP_TIMEOUT, 8'($urandom_range(0, 255)));
        if (run_out)
            repeat (timeout_mirror) send_word(fsp_pkg::OP_TIMEOUT, 8'($urandom_range(0, 255)));
    endtask

    // Mostly good frames; some get a bad trailer, are cut short or are left to expire.
    task automatic random_frame();
        int flaw;
        flaw = $urandom_range(0, 9);
        send_word(fsp_pkg::OP_BYTE, hdr_mirror);
        for (int k = 0; k < fsp_pkg::CHANNELS_DEF; k++)
        begin
            sprinkle_ticks(flaw == 2 && k == 2);
            send_word(fsp_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
            if (flaw == 1 && k == 1)
                return;
        end
        sprinkle_ticks(1'b0);
        if (flaw == 0)
            send_word(fsp_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
        else
            send_word(fsp_pkg::OP_BYTE, trl_mirror);
    endtask

    // Result side: random stalls per word while idling is set, plus one long hold-off on request.
    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_output)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            stall = idling ? $urandom_range(0, 5) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int phase_end;
        int pick;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= fsp_pkg::OP_NONE;
        cfg_valid     <= 1'b0;
        cfg_index     <= fsp_pkg::REG_HEADER;
        cfg_data      <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset settings.
        send_word(fsp_pkg::OP_TIMEOUT, 8'h00);
        send_word(fsp_pkg::OP_NONE, 8'hFF);
        send_word(fsp_pkg::OP_BYTE, 8'h00);
        send_word(fsp_pkg::OP_BYTE, 8'hFF);
        send_word(fsp_pkg::OP_BYTE, 8'hAA);
        send_word(fsp_pkg::OP_BYTE, 8'h00);
        send_word(fsp_pkg::OP_BYTE, 8'hFF);
        send_word(fsp_pkg::OP_BYTE, 8'h80);
        send_word(fsp_pkg::OP_BYTE, 8'h01);
        send_word(fsp_pkg::OP_BYTE, 8'h55);
        repeat (3) send_word(fsp_pkg::OP_PWM, 8'h00);
        send_word(fsp_pkg::OP_BYTE, 8'hAA);
        send_word(fsp_pkg::OP_BYTE, 8'h11);
        send_word(fsp_pkg::OP_BYTE, 8'h22);
        send_word(fsp_pkg::OP_BYTE, 8'h33);
        send_word(fsp_pkg::OP_BYTE, 8'h44);
        send_word(fsp_pkg::OP_BYTE, 8'h00);
        send_word(fsp_pkg::OP_BYTE, 8'hAA);
        send_word(fsp_pkg::OP_BYTE, 8'h5A);
        send_word(fsp_pkg::OP_NONE, 8'h00);

        // The frame left open above expires on the first tick with the shortest limit.
        drain_results();
        write_reg(fsp_pkg::REG_TIMEOUT, 16'd1);
        send_word(fsp_pkg::OP_TIMEOUT, 8'h00);

        // A limit of zero is only met at the counter wrap, so the open frame survives.
        drain_results();
        idling = 1'b0;
        write_reg(fsp_pkg::REG_TIMEOUT, 16'h0000);
        send_word(fsp_pkg::OP_BYTE, hdr_mirror);
        repeat (40) send_word(fsp_pkg::OP_TIMEOUT, 8'h00);
        repeat (4) send_word(fsp_pkg::OP_BYTE, 8'h99);
        send_word(fsp_pkg::OP_BYTE, trl_mirror);

        // Full PWM period with levels at both ends.
        send_word(fsp_pkg::OP_BYTE, hdr_mirror);
        send_word(fsp_pkg::OP_BYTE, 8'hFF);
        send_word(fsp_pkg::OP_BYTE, 8'hFE);
        send_word(fsp_pkg::OP_BYTE, 8'h00);
        send_word(fsp_pkg::OP_BYTE, 8'h01);
        send_word(fsp_pkg::OP_BYTE, trl_mirror);
        repeat (260) send_word(fsp_pkg::OP_PWM, 8'h00);

        for (int p = 0; p < 5; p++)
        begin
            drain_results();
            idling = (p != 3);
            write_reg(fsp_pkg::REG_HEADER, (p == 0) ? 16'h00 : (p == 1) ? 16'hFF :
                      16'($urandom_range(0, 255)));
            write_reg(fsp_pkg::REG_TRAILER, (p == 0) ? 16'hFF : (p == 1) ? 16'h00 :
                      16'($urandom_range(0, 255)));
            write_reg(fsp_pkg::REG_TIMEOUT, (p == 2) ? 16'd1 : 16'($urandom_range(2, 12)));
            if (p == 1)
                hold_output = 1'b1;
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    random_frame();
                else if (pick == 6)
                    send_word(fsp_pkg::opcode_t'(2'($urandom_range(0, 3))),
                              8'($urandom_range(0, 255)));
                else if (pick == 7)
                    repeat ($urandom_range(1, 20))
                        send_word(fsp_pkg::OP_PWM, 8'($urandom_range(0, 255)));
                else if (pick == 8)
                    repeat ($urandom_range(1, timeout_mirror + 1))
                        send_word(fsp_pkg::OP_TIMEOUT, 8'($urandom_range(0, 255)));
                else
                    send_word(fsp_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
            end
        end

        drain_results();
        repeat (4) @(posedge clk);
        $display("Sent %0d words, checked %0d results: %0d frames loaded, %0d errors.",
                 words_sent, checked_words, frames_loaded, error_replies);
        $display("Headers and trailers at 0x00 and 0xFF, timeouts of 1 and 0, one PWM period.");
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
